// File: hw/rtl/planar_pose_integrator_assert.svh
// ----------------------------------------------------------------------------
// planar pose integrator assertion macros
// immediate-consequence and next-cycle checks, both reset-qualified
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_INTEGRATOR_ASSERT_SVH
`define PLANAR_POSE_INTEGRATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PPI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppi same-cycle check failed");

// antecedent implies consequent in the next cycle
`define PPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppi next-cycle check failed");

`endif

// File: hw/rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// shared widths, types and the quarter-wave sine polynomial
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int SINE_W  = 16;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [SINE_W-1:0]  sine_t;
  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] C1      = 64'd1686629713;
  localparam logic [63:0] C3      = 64'd693598674;
  localparam logic [63:0] C5      = 64'd85569307;
  localparam logic [63:0] C7      = 64'd5026995;
  localparam logic [63:0] C9      = 64'd172272;
  localparam logic [63:0] Q15_MAX = 64'd32767;

  // sin(pi/2 * x) for x in unsigned q30, result q15, only used at elaboration
  function automatic logic [14:0] quarter_sine(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = (x_in > Q30_ONE) ? Q30_ONE : x_in;
    x2 = (x * x) >> 30;
    t  = C9;
    t  = C7 - ((x2 * t) >> 30);
    t  = C5 - ((x2 * t) >> 30);
    t  = C3 - ((x2 * t) >> 30);
    t  = C1 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    q  = (s * Q15_MAX + (64'd1 << 29)) >> 30;
    if (q > Q15_MAX) begin
      q = Q15_MAX;
    end
    return q[14:0];
  endfunction

endpackage

// File: hw/rtl/ppi_sine_rom.sv
// ----------------------------------------------------------------------------
// ppi_sine_rom
// full-turn q15 sine lookup from a quarter-wave table, registered read
// ----------------------------------------------------------------------------
module ppi_sine_rom #(
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                       clk,
  input  logic [SINE_INDEX_BITS-1:0] addr,
  output ppi_pkg::sine_t             val
);
  import ppi_pkg::*;

  localparam int QSIZE = 1 << (SINE_INDEX_BITS - 2);
  localparam int IW    = SINE_INDEX_BITS - 1;
  localparam int RW    = SINE_INDEX_BITS - 2;

  typedef logic [14:0] qtab_t [QSIZE+1];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int r = 0; r <= QSIZE; r++) begin
      tab[r] = quarter_sine(64'(r) << (30 - RW));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [1:0]    quad;
  logic [RW-1:0] rem;
  logic [IW-1:0] idx;
  sine_t         mag;

  assign quad = addr[SINE_INDEX_BITS-1 -: 2];
  assign rem  = addr[RW-1:0];
  // second and fourth quadrants mirror the table
  assign idx  = quad[0] ? (IW'(QSIZE) - {1'b0, rem}) : {1'b0, rem};
  assign mag  = {1'b0, QTAB[idx]};

  always_ff @(posedge clk) begin
    val <= quad[1] ? -mag : mag;
  end

endmodule

// File: hw/rtl/ppi_mul.sv
// ----------------------------------------------------------------------------
// ppi_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module ppi_mul (
  input  logic            clk,
  input  ppi_pkg::mul_a_t a,
  input  ppi_pkg::mul_b_t b,
  output ppi_pkg::mul_p_t prod
);
  import ppi_pkg::*;

  always_ff @(posedge clk) begin
    prod <= mul_p_t'(a) * mul_p_t'(b);
  end

endmodule

// File: hw/rtl/planar_pose_integrator.sv
// ----------------------------------------------------------------------------
// planar_pose_integrator
// dead-reckoning pose integrator over one shared multiplier and sine table
// ----------------------------------------------------------------------------
// tick channel: vel_x, vel_y, turn_rate, elapsed with tick_valid/tick_stall.
// a transfer happens at a clock edge with tick_valid high and tick_stall low.
// pose channel: pos_x, pos_y, heading, quat_z, quat_w, the echoed inputs
// and clipped, with pose_valid/pose_stall; one pose per tick.
// each tick runs through a 13-step sequencer: two table reads for the
// current heading, seven passes through the one multiplier (rotation,
// two position steps, heading step), the heading update and two table
// reads for the half heading. pose_valid rises as the sequencer returns
// to idle; a new tick is taken only in idle, never before the last is
// done, at a rate set by the multiplier passes and the single table port.
// tick_stall is low only while the sequencer is idle; a tick may be taken
// while the previous pose still waits. if the receiver stalls, the pose
// holds and the sequencer waits in its last step until the pose is taken.
// reset (rst, synchronous) clears position and heading and drops pose_valid.
// ----------------------------------------------------------------------------
`include "planar_pose_integrator_assert.svh"

module planar_pose_integrator #(
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] turn_rate,
  input  logic [15:0]        elapsed,
  output logic               pose_valid,
  input  logic               pose_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output ppi_pkg::sine_t     quat_z,
  output ppi_pkg::sine_t     quat_w,
  output logic signed [15:0] echo_vel_x,
  output logic signed [15:0] echo_vel_y,
  output logic signed [15:0] echo_turn_rate,
  output logic               clipped
);
  import ppi_pkg::*;

  localparam int N = SINE_INDEX_BITS;
  localparam logic [N-1:0] QTR = N'(1 << (N - 2));
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_C, S_RD_S, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5,
    S_MUL6, S_MUL7, S_YAW, S_RD_HS, S_RD_HC, S_FIN
  } state_t;

  state_t             state;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] wz;
  logic [15:0]        dt;
  sine_t              cos_v;
  sine_t              sin_v;
  sine_t              half_sin;
  logic signed [31:0] acc;
  logic signed [31:0] rot_x;
  logic [31:0]        yaw_angle;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic               clip;

  logic               tick_take;
  logic               pose_load;
  logic [N-1:0]       yaw_idx;
  logic [N-1:0]       half_idx;
  logic [N-1:0]       rom_addr;
  sine_t              rom_val;
  mul_a_t             mul_a;
  mul_b_t             mul_b;
  mul_p_t             prod;
  logic signed [31:0] pos_cur;
  logic signed [32:0] pos_sum;
  logic               pos_ovf;
  logic signed [31:0] pos_next;

  assign tick_stall = (state != S_IDLE);
  assign tick_take  = tick_valid && !tick_stall;
  assign pose_load  = (state == S_FIN) && (!pose_valid || !pose_stall);

  assign yaw_idx  = yaw_angle[31 -: N];
  assign half_idx = {1'b0, yaw_angle[31 -: N-1]};

  always_comb begin
    case (state)
      S_RD_C:  rom_addr = yaw_idx + QTR;
      S_RD_S:  rom_addr = yaw_idx;
      S_RD_HS: rom_addr = half_idx;
      // the half-heading cosine stays on the table output while the pose waits
      S_RD_HC, S_FIN: rom_addr = half_idx + QTR;
      default: rom_addr = yaw_idx;
    endcase
  end

  ppi_sine_rom #(
    .SINE_INDEX_BITS(N)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .val (rom_val)
  );

  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = {{16{vx[15]}}, vx};
        mul_b = {cos_v[15], cos_v};
      end
      S_MUL2: begin
        mul_a = {{16{vy[15]}}, vy};
        mul_b = {sin_v[15], sin_v};
      end
      S_MUL3: begin
        mul_a = {{16{vx[15]}}, vx};
        mul_b = {sin_v[15], sin_v};
      end
      S_MUL4: begin
        mul_a = {{16{vy[15]}}, vy};
        mul_b = {cos_v[15], cos_v};
      end
      S_MUL5: begin
        mul_a = rot_x;
        mul_b = {1'b0, dt};
      end
      S_MUL6: begin
        mul_a = acc;
        mul_b = {1'b0, dt};
      end
      S_MUL7: begin
        mul_a = {{16{wz[15]}}, wz};
        mul_b = {1'b0, dt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ppi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  // step is floor(prod / 2^29) plus bit 28 for round half up, then saturate
  assign pos_cur  = (state == S_MUL6) ? position_x : position_y;
  assign pos_sum  = {pos_cur[31], pos_cur} + 33'($signed(prod[MUL_P_W-1:29]))
                  + 33'({32'd0, prod[28]});
  assign pos_ovf  = (pos_sum[32] != pos_sum[31]);
  assign pos_next = pos_ovf ? (pos_sum[32] ? POS_MIN : POS_MAX) : pos_sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pose_valid <= 1'b0;
      yaw_angle  <= '0;
      position_x <= '0;
      position_y <= '0;
      clip       <= 1'b0;
    end else begin
      if (pose_load) begin
        pose_valid <= 1'b1;
      end else if (pose_valid && !pose_stall) begin
        pose_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick_take) begin
            vx    <= vel_x;
            vy    <= vel_y;
            wz    <= turn_rate;
            dt    <= elapsed;
            state <= S_RD_C;
          end
        end
        S_RD_C: begin
          state <= S_RD_S;
        end
        S_RD_S: begin
          cos_v <= rom_val;
          state <= S_MUL1;
        end
        S_MUL1: begin
          sin_v <= rom_val;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= prod[31:0];
          state <= S_MUL3;
        end
        S_MUL3: begin
          acc   <= acc - prod[31:0];
          state <= S_MUL4;
        end
        S_MUL4: begin
          rot_x <= acc;
          acc   <= prod[31:0];
          state <= S_MUL5;
        end
        S_MUL5: begin
          acc   <= acc + prod[31:0];
          state <= S_MUL6;
        end
        S_MUL6: begin
          position_x <= pos_next;
          clip       <= pos_ovf;
          state      <= S_MUL7;
        end
        S_MUL7: begin
          position_y <= pos_next;
          clip       <= clip | pos_ovf;
          state      <= S_YAW;
        end
        S_YAW: begin
          // heading wraps at a full turn
          yaw_angle <= yaw_angle + prod[31:0];
          state     <= S_RD_HS;
        end
        S_RD_HS: begin
          state <= S_RD_HC;
        end
        S_RD_HC: begin
          half_sin <= rom_val;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (pose_load) begin
            pos_x          <= position_x;
            pos_y          <= position_y;
            heading        <= yaw_angle[31:16];
            quat_z         <= half_sin;
            quat_w         <= rom_val;
            echo_vel_x     <= vx;
            echo_vel_y     <= vy;
            echo_turn_rate <= wz;
            clipped        <= clip;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PPI_ASSERT_NEXT(a_take_starts, clk, rst, tick_take, state == S_RD_C)
  `PPI_ASSERT_NEXT(a_load_shows, clk, rst, pose_load, pose_valid)
  `PPI_ASSERT_SAME(a_clip_at_limit, clk, rst, pose_valid && clipped,
    pos_x == POS_MAX || pos_x == POS_MIN || pos_y == POS_MAX || pos_y == POS_MIN)
  `PPI_ASSERT_SAME(a_half_sine_pos, clk, rst, pose_valid, !quat_z[15])

endmodule
